[design/spr_pkg.sv]
`default_nettype none

package spr_pkg;

	// Register indexes on the configuration port (byte address is 8 times the index).
	localparam logic [1:0] REG_PATTERN_LENGTH     = 2'd0;
	localparam logic [1:0] REG_PATTERN_BYTES      = 2'd1;
	localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd2;
	localparam logic [1:0] REG_REPLACEMENT_BYTES  = 2'd3;

	// Entries in the queue between the matcher and the serializer.
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [3:0]  pattern_length;
		logic [63:0] pattern_bytes;
		logic [3:0]  replacement_length;
		logic [63:0] replacement_bytes;
	} cfg_t;

endpackage

`default_nettype wire

[design/spr_front.sv]
`default_nettype none

module spr_front #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8,
	parameter int SLOTS           = 8,
	parameter int CNT_W           = 4,
	parameter int ENTRY_W         = 69
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire spr_pkg::cfg_t        cfg,
	input  wire logic                 accept,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 in_last,
	output logic                      push,
	output logic [ENTRY_W-1:0]        entry
);

	localparam int CW = $clog2(MAX_PATTERN + 1);
	localparam logic [3:0] PAT_MAX4 = 4'(MAX_PATTERN);
	localparam logic [3:0] REP_MAX4 = 4'(MAX_REPLACEMENT);

	logic [7:0]    window_q [MAX_PATTERN];
	logic [CW-1:0] count_q;

	logic [7:0]    ext      [MAX_PATTERN];
	logic [7:0]    pat      [MAX_PATTERN];
	logic [7:0]    next_win [MAX_PATTERN];
	logic [CW-1:0] ncount;
	logic [CW-1:0] plen;
	logic [CNT_W-1:0] rlen;
	logic [3:0]    plen_full;
	logic [3:0]    rlen_full;
	logic [MAX_PATTERN:0] stop_v;
	logic [CW-1:0] k_sel;
	logic          replace;
	logic [CW-1:0] pass_n;
	logic [CNT_W-1:0] entry_cnt;
	logic [8*SLOTS-1:0] entry_data;

	assign plen_full = (cfg.pattern_length > PAT_MAX4) ? PAT_MAX4 : cfg.pattern_length;
	assign rlen_full = (cfg.replacement_length > REP_MAX4) ? REP_MAX4 : cfg.replacement_length;
	assign plen = CW'(plen_full);
	assign rlen = CNT_W'(rlen_full);
	assign ncount = count_q + CW'(1);

	// Held bytes followed by the incoming byte.
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			ext[j] = (CW'(j) < count_q) ? window_q[j] : in_byte;
			pat[j] = cfg.pattern_bytes[8*j +: 8];
		end
	end

	// For every shift k, decide whether the bytes from k on may stay in the window.
	always_comb begin
		logic [CW-1:0] len_k;
		logic          hit;
		for (int k = 0; k <= MAX_PATTERN; k++) begin
			len_k = ncount - CW'(k);
			hit = (plen != '0) && (len_k <= plen);
			for (int i = 0; i < MAX_PATTERN; i++) begin
				if (i + k < MAX_PATTERN) begin
					if ((CW'(i + k) < ncount) && (ext[i + k] != pat[i])) begin
						hit = 1'b0;
					end
				end
			end
			if (CW'(k) > ncount) begin
				stop_v[k] = 1'b0;
			end else begin
				stop_v[k] = (len_k == '0) ||
					(hit && !((len_k == plen) && (in_last || (k != 0))));
			end
		end
	end

	always_comb begin
		k_sel = CW'(MAX_PATTERN);
		for (int k = MAX_PATTERN; k >= 0; k--) begin
			if (stop_v[k]) begin
				k_sel = CW'(k);
			end
		end
	end

	// A full match can only survive at shift zero, so the replacement never follows passed bytes.
	assign replace = !in_last && (plen != '0) && ((ncount - k_sel) == plen);
	assign pass_n = in_last ? ncount : k_sel;
	assign entry_cnt = replace ? rlen : CNT_W'(pass_n);

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			entry_data[8*s +: 8] = 8'h00;
			if (replace) begin
				if (s < MAX_REPLACEMENT) begin
					entry_data[8*s +: 8] = cfg.replacement_bytes[8*s +: 8];
				end
			end else if (s < MAX_PATTERN) begin
				entry_data[8*s +: 8] = ext[s];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			next_win[j] = 8'h00;
			for (int k = 0; k < MAX_PATTERN; k++) begin
				if ((j + k < MAX_PATTERN) && (k_sel == CW'(k))) begin
					next_win[j] = ext[j + k];
				end
			end
		end
	end

	assign entry = {in_last, entry_cnt, entry_data};
	assign push = accept && (entry_cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (in_last || replace) begin
				count_q <= '0;
			end else begin
				count_q <= ncount - k_sel;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				window_q[j] <= next_win[j];
			end
		end
	end

	// The window is always a proper prefix, so it never fills up between items.
	a_window_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(MAX_PATTERN))
		else $error("pending window reached full depth");

endmodule

`default_nettype wire

[design/spr_queue.sv]
`default_nettype none

module spr_queue #(
	parameter int WIDTH = 69
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  full,
	output logic                  empty
);

	localparam int DEPTH = spr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue read while empty");

endmodule

`default_nettype wire

[design/spr_back.sv]
`default_nettype none

module spr_back #(
	parameter int SLOTS   = 8,
	parameter int CNT_W   = 4,
	parameter int ENTRY_W = 69
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [ENTRY_W-1:0] head,
	input  wire logic               empty,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              out_byte,
	output logic                    out_last
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [8*SLOTS-1:0] head_data;
	logic [CNT_W-1:0]   head_cnt;
	logic               head_last;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;
	logic               load;
	logic               is_end;

	assign head_data = head[8*SLOTS-1:0];
	assign head_cnt  = head[8*SLOTS +: CNT_W];
	assign head_last = head[ENTRY_W-1];

	assign is_end = (CNT_W'(idx_q) == (head_cnt - CNT_W'(1)));
	assign load   = !empty && (!out_valid_q || out_ready);
	assign pop    = load && is_end;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= is_end ? '0 : idx_q + IDX_W'(1);
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head_data[8*idx_q +: 8];
			out_last_q <= head_last && is_end;
		end
	end

	// The front never queues a step that has no bytes to send.
	a_head_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (head_cnt != '0))
		else $error("queue entry with zero bytes");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(out_byte_q) && $stable(out_last_q)))
		else $error("output changed while stalled");

endmodule

`default_nettype wire

[design/stream_pattern_replacer_top.sv]
// Streaming find-and-replace on a byte stream.
// Source bytes arrive on the s_axis channel, one byte per transfer, with tlast
// on the final byte of the stream. Rewritten bytes leave on the m_axis channel,
// where tlast marks the final byte of the rewritten stream. Every leftmost,
// non-overlapping occurrence of the pattern that is followed by at least one
// more source byte is replaced; other bytes pass through in order.
// The pattern and replacement are set through the APB port (64-bit registers at
// byte addresses 0, 8, 16 and 24) while the stream is idle; pready is always high.
// The matcher writes the bytes caused by a source transfer into the queue at
// the transfer's own clock edge; the serializer then registers the first of
// them into its output register, from which it is offered on m_axis.
// Throughput is one source byte per cycle while each source byte causes at
// most one output byte and m_axis takes every byte; the serializer sends one
// byte per cycle while m_axis is ready, and a four-entry queue between matcher
// and serializer absorbs the bursts of a replacement or a flush of held bytes.
// When m_axis stalls, the output register holds, the queue fills and
// s_axis_tready drops once it is full. Reset empties the window and the queue
// and loads pattern_length 1 with all other registers zero.

`default_nettype none

module stream_pattern_replacer_top #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // in_byte
	input  wire logic        s_axis_tlast,   // in_last

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // out_byte
	output logic             m_axis_tlast    // out_last
);

	// A queue entry holds up to SLOTS bytes, their count and the final-byte flag.
	localparam int SLOTS   = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int ENTRY_W = 8 * SLOTS + CNT_W + 1;

	spr_pkg::cfg_t cfg_q;
	logic          cfg_write;
	logic [1:0]    reg_idx;

	logic               in_accept;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;
	logic [ENTRY_W-1:0] entry;
	logic [ENTRY_W-1:0] head;

	// Configuration registers. A write completes in the access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_length     <= 4'd1;
			cfg_q.pattern_bytes      <= '0;
			cfg_q.replacement_length <= '0;
			cfg_q.replacement_bytes  <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				spr_pkg::REG_PATTERN_LENGTH:     cfg_q.pattern_length     <= pwdata[3:0];
				spr_pkg::REG_PATTERN_BYTES:      cfg_q.pattern_bytes      <= pwdata;
				spr_pkg::REG_REPLACEMENT_LENGTH: cfg_q.replacement_length <= pwdata[3:0];
				spr_pkg::REG_REPLACEMENT_BYTES:  cfg_q.replacement_bytes  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			spr_pkg::REG_PATTERN_LENGTH:     prdata = {60'd0, cfg_q.pattern_length};
			spr_pkg::REG_PATTERN_BYTES:      prdata = cfg_q.pattern_bytes;
			spr_pkg::REG_REPLACEMENT_LENGTH: prdata = {60'd0, cfg_q.replacement_length};
			spr_pkg::REG_REPLACEMENT_BYTES:  prdata = cfg_q.replacement_bytes;
			default:                         prdata = '0;
		endcase
	end

	// The matcher takes a byte whenever the queue has room, so the input side
	// keeps moving while the serializer is busy or stalled.
	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	spr_front #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT),
		.SLOTS           (SLOTS),
		.CNT_W           (CNT_W),
		.ENTRY_W         (ENTRY_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (in_accept),
		.in_byte (s_axis_tdata),
		.in_last (s_axis_tlast),
		.push    (push),
		.entry   (entry)
	);

	spr_queue #(
		.WIDTH (ENTRY_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (entry),
		.pop    (pop),
		.dout   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// The serializer sends the queued bytes one per transfer from its output register.
	spr_back #(
		.SLOTS   (SLOTS),
		.CNT_W   (CNT_W),
		.ENTRY_W (ENTRY_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

[tb/stream_pattern_replacer_top_tb.sv]
`timescale 1ns / 100ps

// One byte on the rewritten stream.
typedef struct packed {
	logic [7:0] data;
	logic       last;
} rewritten_t;

// Keeps its own copy of the registers and the held window, works out the
// rewritten bytes for each source byte, and compares what the block sends.
class rewrite_scoreboard;
	logic [3:0]  pattern_length     = 4'd1;
	logic [63:0] pattern_bytes      = '0;
	logic [3:0]  replacement_length = '0;
	logic [63:0] replacement_bytes  = '0;
	logic [7:0]  held [8];
	int unsigned held_count = 0;
	rewritten_t  expected_bytes [$];
	int unsigned errors = 0;

	function void write_register(logic [1:0] index, logic [63:0] value);
		case (index)
			spr_pkg::REG_PATTERN_LENGTH:     pattern_length = value[3:0];
			spr_pkg::REG_PATTERN_BYTES:      pattern_bytes = value;
			spr_pkg::REG_REPLACEMENT_LENGTH: replacement_length = value[3:0];
			spr_pkg::REG_REPLACEMENT_BYTES:  replacement_bytes = value;
			default: ;
		endcase
	endfunction

	// Appends one expected byte at the end of the queue.
	function void expect_byte(logic [7:0] data, logic last);
		rewritten_t item;
		item.data = data;
		item.last = last;
		expected_bytes.insert(expected_bytes.size(), item);
	endfunction

	// True when the held bytes are a prefix of the pattern, the whole pattern included.
	function bit held_is_prefix(int unsigned len);
		if (len == 0 || held_count > len) return 1'b0;
		for (int unsigned i = 0; i < held_count; i++)
			if (held[i] != pattern_bytes[8*i +: 8]) return 1'b0;
		return 1'b1;
	endfunction

	function void release_front();
		expect_byte(held[0], 1'b0);
		for (int unsigned i = 1; i < held_count; i++) held[i-1] = held[i];
		held_count--;
	endfunction

	function void note_source_byte(logic [7:0] data, logic last);
		int unsigned plen, rlen, passed, first;
		rewritten_t tail;
		plen = (pattern_length > 8) ? 8 : pattern_length;
		rlen = (replacement_length > 8) ? 8 : replacement_length;
		passed = 0;
		first = expected_bytes.size();
		if (held_count >= 8) begin
			release_front();
			passed++;
		end
		held[held_count] = data;
		held_count++;
		// A complete match is not taken on the final byte, nor when this step
		// already had to pass bytes through after a pattern change.
		while (held_count > 0 && (!held_is_prefix(plen) ||
				(held_count == plen && (last || passed > 0)))) begin
			release_front();
			passed++;
		end
		if (last) begin
			while (held_count > 0) release_front();
			if (expected_bytes.size() > first) begin
				tail = expected_bytes[expected_bytes.size() - 1];
				tail.last = 1'b1;
				expected_bytes[expected_bytes.size() - 1] = tail;
			end
		end else if (plen > 0 && held_count == plen) begin
			for (int unsigned i = 0; i < rlen; i++)
				expect_byte(replacement_bytes[8*i +: 8], 1'b0);
			held_count = 0;
		end
	endfunction

	function void check_rewritten_byte(logic [7:0] data, logic last);
		rewritten_t want;
		if (expected_bytes.size() == 0) begin
			$display("%0t: output byte %02h last %0b with nothing expected", $time, data, last);
			errors++;
			return;
		end
		want = expected_bytes.pop_front();
		if (want.data !== data) begin
			$display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
			errors++;
		end
		if (want.last !== last) begin
			$display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
			errors++;
		end
	endfunction

	function int unsigned outstanding();
		return expected_bytes.size();
	endfunction
endclass

module stream_pattern_replacer_top_tb;

	// Far beyond the slowest correct run: about 410 source bytes, each with up
	// to eight rewritten bytes that may each wait out a receiver stall.
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // in_byte
	logic        s_axis_tlast = 1'b0; // in_last

	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // out_byte
	logic        m_axis_tlast;        // out_last

	rewrite_scoreboard rewrites;

	// When calm is set, neither side inserts idle cycles.
	bit          calm = 1'b0;
	// A nonzero value asks the receiver to start a tready-low hold counted down from that value.
	int unsigned long_hold = 0;
	// Pattern of the current phase and how many of its bytes are matched;
	// the random stream is built from pieces of it.
	logic [63:0] search_word = '0;
	int unsigned search_span = 1;

	stream_pattern_replacer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// APB write: a setup cycle, then an access cycle. The register is written at
	// the edge where psel and penable are both seen high, which is also when the
	// scoreboard takes the new value.
	task automatic write_register(input logic [1:0] index, input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rewrites.write_register(index, value);
	endtask

	// Offers one source byte and returns at the edge where the transfer happens.
	// tvalid is only lowered when an idle burst comes first, so a byte that
	// follows straight on never sees tvalid lowered and raised in one step.
	task automatic send_byte(input logic [7:0] data, input logic last);
		int unsigned gap;
		gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		rewrites.note_source_byte(data, last);
	endtask

	// Sends count bytes of a word, first byte from the lowest bits.
	task automatic send_bytes(input logic [63:0] word, input int unsigned count,
			input logic last_on_final);
		for (int unsigned i = 0; i < count; i++)
			send_byte(word[8*i +: 8], last_on_final && i == count - 1);
	endtask

	// Stops offering bytes, waits for every expected byte, then lets the
	// pipeline settle, since the final source byte may have caused no output.
	task automatic wait_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (rewrites.outstanding() != 0);
		repeat (8) @(posedge clk);
	endtask

	// Random registers. Patterns are drawn from two symbols so that partial
	// matches, overlaps and self-similar patterns are common; lengths now and
	// then exceed the limit to exercise saturation.
	task automatic load_random_setup();
		logic [7:0]  sym [2];
		logic [63:0] pat;
		logic [3:0]  plen, rlen;
		int unsigned pick;
		sym[0] = 8'($urandom);
		sym[1] = 8'($urandom);
		pick = $urandom_range(0, 5);
		if (pick == 0) pat = '0;
		else if (pick == 1) pat = '1;
		else for (int i = 0; i < 8; i++) pat[8*i +: 8] = sym[$urandom_range(0, 1)];
		pick = $urandom_range(0, 9);
		plen = (pick == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
		pick = $urandom_range(0, 9);
		rlen = (pick == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
		write_register(spr_pkg::REG_PATTERN_BYTES, pat);
		write_register(spr_pkg::REG_PATTERN_LENGTH, {60'd0, plen});
		write_register(spr_pkg::REG_REPLACEMENT_BYTES, {$urandom, $urandom});
		write_register(spr_pkg::REG_REPLACEMENT_LENGTH, {60'd0, rlen});
		search_word = pat;
		search_span = (plen > 8) ? 8 : plen;
	endtask

	// Mostly well-formed material: whole patterns and pattern prefixes, mixed
	// with symbols of the pattern and fully random bytes. The stream end flag
	// falls at random, also in the middle of a pattern.
	task automatic send_random_stream(input int unsigned count);
		int unsigned sent, take, kind;
		logic [7:0]  data;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) take = search_span;
			else if (kind < 6) take = $urandom_range(1, search_span);
			else take = 1;
			for (int unsigned i = 0; i < take && sent < count; i++) begin
				if (kind < 6) data = search_word[8*i +: 8];
				else if ($urandom_range(0, 1) == 1)
					data = search_word[8*$urandom_range(0, 7) +: 8];
				else data = 8'($urandom);
				send_byte(data, $urandom_range(0, 24) == 0);
				sent++;
			end
		end
	endtask

	// Receiver: checks each output transfer and stalls in random bursts.
	// A long hold requested by the stimulus is counted down here, so the
	// internal queue fills and the block stalls its input.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				rewrites.check_rewritten_byte(m_axis_tdata, m_axis_tlast);
			if (long_hold > 0) begin
				stall_left = long_hold;
				long_hold = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 6);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Cycle counter that ends a run which hangs.
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("stream_pattern_replacer_top test failed");
		$finish;
	end

	initial begin
		rewrites = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: a one-byte pattern of zero with an empty replacement,
		// so a zero byte is deleted unless it is the final byte.
		send_bytes(64'h00_FF_00, 3, 1'b1);
		wait_until_drained();

		// Pattern x a b, eight-byte replacement. A leftmost match after a
		// false start is replaced; the same pattern ending on the final byte
		// passes through. The run then stops with x a held in the window.
		write_register(spr_pkg::REG_PATTERN_LENGTH, 64'd3);
		write_register(spr_pkg::REG_PATTERN_BYTES, 64'h62_61_78);
		write_register(spr_pkg::REG_REPLACEMENT_LENGTH, 64'd8);
		write_register(spr_pkg::REG_REPLACEMENT_BYTES, 64'hFEDC_BA98_7654_3210);
		send_bytes(64'h6261_7800_6261_7878, 8, 1'b1);
		send_bytes(64'h61_78, 2, 1'b0);
		wait_until_drained();

		// New pattern a b while x a is held: the next b must push x out first,
		// so the a b left at the front is not taken as a match and passes too.
		// A later a b is replaced by a single zero byte.
		write_register(spr_pkg::REG_PATTERN_LENGTH, 64'd2);
		write_register(spr_pkg::REG_PATTERN_BYTES, 64'h62_61);
		write_register(spr_pkg::REG_REPLACEMENT_LENGTH, 64'd1);
		write_register(spr_pkg::REG_REPLACEMENT_BYTES, 64'h0);
		send_bytes(64'hFF_62_61_62, 4, 1'b1);
		wait_until_drained();

		// An all-ones length word saturates to an eight-byte pattern of 0xFF,
		// deleted by an empty replacement.
		write_register(spr_pkg::REG_PATTERN_LENGTH, '1);
		write_register(spr_pkg::REG_PATTERN_BYTES, '1);
		write_register(spr_pkg::REG_REPLACEMENT_LENGTH, 64'd0);
		send_bytes('1, 8, 1'b0);
		send_bytes(64'h00, 1, 1'b1);
		wait_until_drained();

		// Random phases. Each starts from an idle block, possibly with bytes
		// still held from the previous phase; the last two run without idling.
		for (int unsigned phase = 0; phase < 8; phase++) begin
			calm = (phase >= 6);
			load_random_setup();
			if (phase == 0) begin
				// Zero pattern length turns matching off.
				write_register(spr_pkg::REG_PATTERN_LENGTH, 64'd0);
				search_span = 8;
			end
			if (phase == 1) write_register(spr_pkg::REG_REPLACEMENT_LENGTH, '1);
			if (phase == 2) begin
				send_random_stream(10);
				long_hold = 60;
				send_random_stream(38);
			end else if (phase == 4) begin
				send_random_stream(24);
				wait_until_drained();
				send_random_stream(24);
			end else begin
				send_random_stream(48);
			end
			wait_until_drained();
		end

		if (rewrites.errors == 0 && rewrites.outstanding() == 0) begin
			$display("stream_pattern_replacer_top test passed");
		end else begin
			$display("stream_pattern_replacer_top test failed");
		end
		$finish;
	end

endmodule

[sim.f]
design/spr_pkg.sv
design/spr_front.sv
design/spr_queue.sv
design/spr_back.sv
design/stream_pattern_replacer_top.sv
tb/stream_pattern_replacer_top_tb.sv
